@@ design/barrett_modular_field_alu_defines.svh @@
// ---------------------------------------------------------------------------
// barrett modular field alu assertion macros
// shared concurrent assertion forms, clocked on clk and held off in rst
// ---------------------------------------------------------------------------
`ifndef BARRETT_MODULAR_FIELD_ALU_DEFINES_SVH
`define BARRETT_MODULAR_FIELD_ALU_DEFINES_SVH

// consequent must hold in the same cycle
`define BMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the next cycle
`define BMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bma_pkg.sv @@
// ---------------------------------------------------------------------------
// bma_pkg
// item types, operation codes and widths of the barrett modular field alu
// ---------------------------------------------------------------------------
package bma_pkg;

  localparam int LIMB_W    = 64;
  localparam int NUM_LIMBS = 4;
  localparam int FIELD_W   = LIMB_W * NUM_LIMBS;
  localparam int RED_W     = FIELD_W + 1;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_SUB = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [LIMB_W-1:0] a_w0;
    logic [LIMB_W-1:0] a_w1;
    logic [LIMB_W-1:0] a_w2;
    logic [LIMB_W-1:0] a_w3;
    logic [LIMB_W-1:0] b_w0;
    logic [LIMB_W-1:0] b_w1;
    logic [LIMB_W-1:0] b_w2;
    logic [LIMB_W-1:0] b_w3;
  } req_t;

  typedef struct packed {
    logic [LIMB_W-1:0] res_w0;
    logic [LIMB_W-1:0] res_w1;
    logic [LIMB_W-1:0] res_w2;
    logic [LIMB_W-1:0] res_w3;
    logic              range_error;
  } res_t;

  typedef struct packed {
    logic [1:0]       op;
    logic             err;
    logic [RED_W-1:0] asr;
  } side_t;

  typedef struct packed {
    side_t            s;
    logic [RED_W-1:0] tlo;
  } side2_t;

endpackage

@@ design/bma_front.sv @@
// ---------------------------------------------------------------------------
// bma_front
// input stage: range check against the modulus and modular add/sub sums
// ---------------------------------------------------------------------------
module bma_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  bma_pkg::req_t                in_item,
  input  logic [bma_pkg::FIELD_W-1:0]  m,
  output logic                         out_valid,
  output bma_pkg::side_t               side,
  output logic [bma_pkg::FIELD_W-1:0]  a,
  output logic [bma_pkg::FIELD_W-1:0]  b
);

  logic [bma_pkg::FIELD_W-1:0] a_in;
  logic [bma_pkg::FIELD_W-1:0] b_in;
  bma_pkg::side_t              side_next;

  always_comb begin
    a_in = {in_item.a_w3, in_item.a_w2, in_item.a_w1, in_item.a_w0};
    b_in = {in_item.b_w3, in_item.b_w2, in_item.b_w1, in_item.b_w0};
    side_next.op  = in_item.req_type;
    side_next.err = (in_item.req_type == bma_pkg::OP_MUL ||
                     in_item.req_type == bma_pkg::OP_ADD ||
                     in_item.req_type == bma_pkg::OP_SUB) &&
                    (a_in >= m || b_in >= m);
    if (in_item.req_type == bma_pkg::OP_SUB) begin
      side_next.asr = bma_pkg::RED_W'(a_in) + bma_pkg::RED_W'(m) - bma_pkg::RED_W'(b_in);
    end else begin
      side_next.asr = bma_pkg::RED_W'(a_in) + bma_pkg::RED_W'(b_in);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side <= side_next;
      a    <= a_in;
      b    <= b_in;
    end
  end

endmodule

@@ design/bma_mul.sv @@
// ---------------------------------------------------------------------------
// bma_mul
// pipelined multiplier: 32x32 partial products, row sums, registered add tree
// ---------------------------------------------------------------------------
module bma_mul #(
  parameter int WX = 256,
  parameter int WY = 256,
  parameter int WS = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [WX-1:0]    x,
  input  logic [WY-1:0]    y,
  input  logic [WS-1:0]    side_in,
  output logic             out_valid,
  output logic [WX+WY-1:0] p,
  output logic [WS-1:0]    side_out
);

  localparam int D   = 32;
  localparam int NX  = (WX + D - 1) / D;
  localparam int NY  = (WY + D - 1) / D;
  localparam int WXP = NX * D;
  localparam int WYP = NY * D;
  localparam int WP  = WX + WY;
  localparam int WW  = WXP + WYP;
  localparam int WE  = (NY + 1) * D;
  localparam int LV  = (NX > 1) ? $clog2(NX) : 0;
  localparam int NR  = 1 << LV;
  localparam int LAT = 2 + LV;

  logic [WXP-1:0]  xp;
  logic [WYP-1:0]  yp;
  logic [2*D-1:0]  pp [NX][NY];
  logic [WP-1:0]   node [LV+1][NR];
  logic            vld [LAT];
  logic [WS-1:0]   sd [LAT];

  assign xp = WXP'(x);
  assign yp = WYP'(y);

  // partial products
  for (genvar i = 0; i < NX; i++) begin : g_px
    for (genvar j = 0; j < NY; j++) begin : g_py
      always_ff @(posedge clk) begin
        if (en) begin
          pp[i][j] <= (2*D)'(xp[i*D +: D]) * (2*D)'(yp[j*D +: D]);
        end
      end
    end
  end

  // row sums: even and odd products do not overlap
  for (genvar i = 0; i < NR; i++) begin : g_row
    if (i < NX) begin : g_live
      logic [WE-1:0] ev;
      logic [WE-1:0] od;
      always_comb begin
        ev = '0;
        od = '0;
        for (int j = 0; j < NY; j++) begin
          if (j % 2 == 0) begin
            ev[j*D +: 2*D] = pp[i][j];
          end else begin
            od[j*D +: 2*D] = pp[i][j];
          end
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          node[0][i] <= WP'(WW'(ev + od) << (i * D));
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        if (en) begin
          node[0][i] <= '0;
        end
      end
    end
  end

  // add tree
  for (genvar l = 0; l < LV; l++) begin : g_lvl
    for (genvar k = 0; k < NR; k++) begin : g_node
      if (k < (NR >> (l + 1))) begin : g_add
        always_ff @(posedge clk) begin
          if (en) begin
            node[l+1][k] <= node[l][2*k] + node[l][2*k+1];
          end
        end
      end else begin : g_idle
        always_ff @(posedge clk) begin
          if (en) begin
            node[l+1][k] <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < LAT; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid;
      for (int s = 1; s < LAT; s++) begin
        vld[s] <= vld[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= side_in;
      for (int s = 1; s < LAT; s++) begin
        sd[s] <= sd[s-1];
      end
    end
  end

  assign p         = node[LV][0];
  assign out_valid = vld[LAT-1];
  assign side_out  = sd[LAT-1];

endmodule

@@ design/bma_tail.sv @@
// ---------------------------------------------------------------------------
// bma_tail
// barrett remainder, final conditional subtraction and output register
// ---------------------------------------------------------------------------
`include "barrett_modular_field_alu_defines.svh"

module bma_tail (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  bma_pkg::side2_t              side,
  input  logic [bma_pkg::RED_W-1:0]    qm_lo,
  input  logic [bma_pkg::FIELD_W-1:0]  m,
  output logic                         out_valid,
  output bma_pkg::res_t                out_item
);

  logic                        v1;
  logic [1:0]                  op1;
  logic                        err1;
  logic [bma_pkg::RED_W-1:0]   r1;
  logic [bma_pkg::RED_W-1:0]   r_next;
  logic [bma_pkg::RED_W-1:0]   m_ext;
  logic [bma_pkg::RED_W-1:0]   d;
  logic [bma_pkg::FIELD_W-1:0] res;
  bma_pkg::res_t               out_next;

  always_comb begin
    if (side.s.op == bma_pkg::OP_MUL) begin
      r_next = side.tlo - qm_lo;
    end else begin
      r_next = side.s.asr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1   <= r_next;
      op1  <= side.s.op;
      err1 <= side.s.err;
    end
  end

  always_comb begin
    m_ext = bma_pkg::RED_W'(m);
    d     = (r1 >= m_ext) ? r1 - m_ext : r1;
    if (err1 || !(op1 == bma_pkg::OP_MUL || op1 == bma_pkg::OP_ADD ||
                  op1 == bma_pkg::OP_SUB)) begin
      res = '0;
    end else begin
      res = d[bma_pkg::FIELD_W-1:0];
    end
    out_next.res_w0      = res[0*bma_pkg::LIMB_W +: bma_pkg::LIMB_W];
    out_next.res_w1      = res[1*bma_pkg::LIMB_W +: bma_pkg::LIMB_W];
    out_next.res_w2      = res[2*bma_pkg::LIMB_W +: bma_pkg::LIMB_W];
    out_next.res_w3      = res[3*bma_pkg::LIMB_W +: bma_pkg::LIMB_W];
    out_next.range_error = err1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= out_next;
    end
  end

  `BMA_ASSERT_NOW(a_err_zero, out_valid && out_item.range_error, out_item.res_w0 == '0 && out_item.res_w1 == '0 && out_item.res_w2 == '0 && out_item.res_w3 == '0, "range error item with nonzero result")
  `BMA_ASSERT_NEXT(a_tail_adv, v1 && en, out_valid, "tail item lost on advance")

endmodule

@@ design/barrett_modular_field_alu.sv @@
// ---------------------------------------------------------------------------
// barrett_modular_field_alu
// 256-bit modular multiply, add and subtract with barrett reduction
// ---------------------------------------------------------------------------
// Takes one item per clock and passes it through one input
// stage, three multipliers in series (a*b in 5 stages, t*mu in 6 stages, the
// low bits of q*m in 5 stages, each built from 32x32 partial products and a
// registered add tree) and two remainder stages. The whole pipeline holds
// while a result waits under out_stall. Write modulus and mu only while idle.
`include "barrett_modular_field_alu_defines.svh"

module barrett_modular_field_alu (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bma_pkg::req_t                  in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bma_pkg::res_t                  out_item,
  input  logic                           cfg_we,
  input  logic [bma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bma_pkg::LIMB_W-1:0]     cfg_data
);

  localparam int TW  = 2 * bma_pkg::FIELD_W;
  localparam int S1W = $bits(bma_pkg::side_t);
  localparam int S2W = $bits(bma_pkg::side2_t);

  logic [bma_pkg::LIMB_W-1:0]  modulus [bma_pkg::NUM_LIMBS];
  logic [bma_pkg::LIMB_W-1:0]  mu_low [bma_pkg::NUM_LIMBS];
  logic [bma_pkg::FIELD_W-1:0] m;
  logic [bma_pkg::RED_W-1:0]   mu;
  logic                        en;

  logic                        f_valid;
  bma_pkg::side_t              f_side;
  logic [bma_pkg::FIELD_W-1:0] f_a;
  logic [bma_pkg::FIELD_W-1:0] f_b;

  logic                        m1_valid;
  logic [TW-1:0]               m1_p;
  logic [S1W-1:0]              m1_side;
  bma_pkg::side2_t             m2_in;

  logic                        m2_valid;
  logic [TW+bma_pkg::RED_W-1:0] m2_p;
  logic [S2W-1:0]              m2_side;

  logic                        m3_valid;
  logic [bma_pkg::FIELD_W+bma_pkg::RED_W-1:0] m3_p;
  logic [S2W-1:0]              m3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bma_pkg::NUM_LIMBS; i++) begin
        modulus[i] <= '0;
        mu_low[i]  <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index < bma_pkg::CFG_IDX_W'(bma_pkg::NUM_LIMBS)) begin
        modulus[cfg_index[1:0]] <= cfg_data;
      end else begin
        mu_low[cfg_index[1:0]] <= cfg_data;
      end
    end
  end

  assign m        = {modulus[3], modulus[2], modulus[1], modulus[0]};
  assign mu       = {1'b1, mu_low[3], mu_low[2], mu_low[1], mu_low[0]};
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  bma_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .m         (m),
    .out_valid (f_valid),
    .side      (f_side),
    .a         (f_a),
    .b         (f_b)
  );

  bma_mul #(
    .WX (bma_pkg::FIELD_W),
    .WY (bma_pkg::FIELD_W),
    .WS (S1W)
  ) u_mul_ab (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .x         (f_a),
    .y         (f_b),
    .side_in   (f_side),
    .out_valid (m1_valid),
    .p         (m1_p),
    .side_out  (m1_side)
  );

  assign m2_in.s   = bma_pkg::side_t'(m1_side);
  assign m2_in.tlo = m1_p[bma_pkg::RED_W-1:0];

  bma_mul #(
    .WX (TW),
    .WY (bma_pkg::RED_W),
    .WS (S2W)
  ) u_mul_tmu (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m1_valid),
    .x         (m1_p),
    .y         (mu),
    .side_in   (m2_in),
    .out_valid (m2_valid),
    .p         (m2_p),
    .side_out  (m2_side)
  );

  bma_mul #(
    .WX (bma_pkg::FIELD_W),
    .WY (bma_pkg::RED_W),
    .WS (S2W)
  ) u_mul_qm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m2_valid),
    .x         (m),
    .y         (m2_p[TW +: bma_pkg::RED_W]),
    .side_in   (m2_side),
    .out_valid (m3_valid),
    .p         (m3_p),
    .side_out  (m3_side)
  );

  bma_tail u_tail (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m3_valid),
    .side      (bma_pkg::side2_t'(m3_side)),
    .qm_lo     (m3_p[bma_pkg::RED_W-1:0]),
    .m         (m),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  `BMA_ASSERT_NOW(a_hold_input, out_valid && out_stall, in_stall, "item taken while result is held")

endmodule
